// ===== rtl/core/fsb_pkg.sv =====
// Shared types and constants for the flashlight SOS blink driver.
`default_nettype none

package fsb_pkg;

  // Tick count width and blink rate (LED toggles when low bits are zero)
  localparam int CNT_W       = 16;
  localparam int BLINK_SHIFT = 4;

  // Morse unit register
  localparam int              UNIT_W     = 12;
  localparam logic [UNIT_W-1:0] UNIT_RESET = 12'd15;

  // SOS sequencer
  localparam int              STEP_W    = 5;
  localparam logic [STEP_W-1:0] STEP_LAST = 5'd18;
  localparam logic [STEP_W-1:0] STEP_GAP_A = 5'd7;
  localparam logic [STEP_W-1:0] STEP_GAP_B = 5'd9;
  localparam logic [STEP_W-1:0] STEP_GAP_C = 5'd11;

  // Configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_UNIT_TICKS = 1'b0;   // register index (paddr[2])

  // Stream widths
  localparam int IN_DW  = 16;
  localparam int OUT_DW = 8;

  typedef enum logic {
    KIND_TICK  = 1'b0,
    KIND_PRESS = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_ON    = 2'd1,
    MODE_BLINK = 2'd2,
    MODE_SOS   = 2'd3
  } light_mode_t;

  // One registered input word
  typedef struct packed {
    kind_t            kind;
    logic [CNT_W-1:0] count;
  } item_t;

endpackage

`default_nettype wire

// ===== rtl/core/flashlight_sos_blink_driver.sv =====
// Top level of the flashlight LED driver: off, on, blink and Morse SOS.
`default_nettype none

// Each input word is either a tick (tuser 0, tdata = free-running tick count)
// or a button press (tuser 1), and each gives exactly one result word with
// the LED level and the mode after it. The block takes one word per clock
// cycle while the output is not stalled by m_axis_tready; a word passes
// through the input register and then the result register. The mode and
// sequencer state is read and rewritten as each word moves into the result
// register. unit_ticks (APB offset 0) sets the Morse unit and should be
// written only while no words are in flight.
module flashlight_sos_blink_driver (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // stream in
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [fsb_pkg::IN_DW-1:0]  s_axis_tdata,  // [15:0] blink_counter
  input  wire logic                       s_axis_tuser,  // [0] mode (0 tick, 1 press)
  // stream out
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic      [fsb_pkg::OUT_DW-1:0] m_axis_tdata,  // [0] led_on, [2:1] flash_mode
  // APB configuration
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [fsb_pkg::APB_AW-1:0] paddr,
  input  wire logic [fsb_pkg::APB_DW-1:0] pwdata,
  output logic      [fsb_pkg::APB_DW-1:0] prdata,
  output logic                            pready
);
  import fsb_pkg::*;

  logic              item_valid;
  item_t             item;
  logic              item_take;
  logic [UNIT_W-1:0] unit_ticks;

  fsb_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .unit_ticks (unit_ticks)
  );

  fsb_in_stage u_in (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .item_valid    (item_valid),
    .item          (item),
    .item_take     (item_take)
  );

  fsb_engine u_engine (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item          (item),
    .item_take     (item_take),
    .unit_ticks    (unit_ticks),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== rtl/core/fsb_cfg.sv =====
// APB register block holding the Morse unit length.
`default_nettype none

module fsb_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [fsb_pkg::APB_AW-1:0] paddr,
  input  wire logic [fsb_pkg::APB_DW-1:0] pwdata,
  output logic      [fsb_pkg::APB_DW-1:0] prdata,
  output logic                            pready,
  output logic      [fsb_pkg::UNIT_W-1:0] unit_ticks
);
  import fsb_pkg::*;

  logic wr_en;
  logic reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_UNIT_TICKS);
  assign wr_en   = psel & penable & pwrite & pready & reg_hit;

  // Register write
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_ticks <= UNIT_RESET;
    end else if (wr_en) begin
      unit_ticks <= pwdata[UNIT_W-1:0];
    end
  end

  // Read back, zero outside the register map
  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata = {{(APB_DW-UNIT_W){1'b0}}, unit_ticks};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fsb_in_stage.sv =====
// Input register stage of the stream slave side.
`default_nettype none

module fsb_in_stage (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [fsb_pkg::IN_DW-1:0] s_axis_tdata,
  input  wire logic                      s_axis_tuser,
  output logic                           item_valid,
  output fsb_pkg::item_t                 item,
  input  wire logic                      item_take
);
  import fsb_pkg::*;

  // Free when empty or when the held word moves on this cycle
  assign s_axis_tready = !item_valid || item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tready) begin
      item_valid <= s_axis_tvalid;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item.kind  <= kind_t'(s_axis_tuser);
      item.count <= s_axis_tdata[CNT_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fsb_engine.sv =====
// Mode state machine, blink and SOS sequencer, and the result register.
`default_nettype none

module fsb_engine (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       item_valid,
  input  wire fsb_pkg::item_t             item,
  output logic                            item_take,
  input  wire logic [fsb_pkg::UNIT_W-1:0] unit_ticks,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic      [fsb_pkg::OUT_DW-1:0] m_axis_tdata
);
  import fsb_pkg::*;

  light_mode_t       light_mode, light_mode_next;
  logic              led_level, led_level_next;
  logic [STEP_W-1:0] sos_step, sos_step_next;
  logic [CNT_W-1:0]  sos_deadline, sos_deadline_next;

  logic              res_led;
  light_mode_t       res_mode;

  logic [UNIT_W+2:0] seven_u;
  logic [UNIT_W+1:0] three_u;
  logic [CNT_W-1:0]  diff;
  logic              resync;
  logic              due;
  logic [CNT_W-1:0]  gap;
  logic              press;

  // Word moves into the result register when that is free
  assign item_take = item_valid && (!m_axis_tvalid || m_axis_tready);
  assign press     = (item.kind == KIND_PRESS);

  // Unit multiples and deadline compare
  assign seven_u = {unit_ticks, 3'b000} - {3'b000, unit_ticks};
  assign three_u = {unit_ticks, 1'b0} + {2'b00, unit_ticks};
  assign diff    = item.count - sos_deadline;
  assign resync  = $signed({diff[CNT_W-1], diff}) >
                   $signed({{(CNT_W-UNIT_W-2){1'b0}}, seven_u});
  assign due     = (item.count == sos_deadline);

  // Gap to the next deadline after the current step
  always_comb begin
    priority if (sos_step >= STEP_LAST) begin
      gap = {{(CNT_W-UNIT_W-3){1'b0}}, seven_u};
    end else if (sos_step == STEP_GAP_A || sos_step == STEP_GAP_B ||
                 sos_step == STEP_GAP_C) begin
      gap = {{(CNT_W-UNIT_W-2){1'b0}}, three_u};
    end else begin
      gap = {{(CNT_W-UNIT_W){1'b0}}, unit_ticks};
    end
  end

  // Next mode: button press cycles off, on, blink, SOS
  always_comb begin
    light_mode_next = light_mode;
    if (press) begin
      unique case (light_mode)
        MODE_OFF:   light_mode_next = MODE_ON;
        MODE_ON:    light_mode_next = MODE_BLINK;
        MODE_BLINK: light_mode_next = MODE_SOS;
        MODE_SOS:   light_mode_next = MODE_OFF;
        default:    light_mode_next = MODE_OFF;
      endcase
    end
  end

  // LED level and SOS sequencer
  always_comb begin
    led_level_next    = led_level;
    sos_step_next     = sos_step;
    sos_deadline_next = sos_deadline;
    if (press) begin
      unique case (light_mode)
        MODE_OFF: led_level_next = 1'b1;
        MODE_SOS: led_level_next = 1'b0;
        default:  led_level_next = led_level;
      endcase
    end else begin
      unique case (light_mode)
        MODE_BLINK: begin
          if (item.count[BLINK_SHIFT-1:0] == '0) begin
            led_level_next = !led_level;
          end
        end
        MODE_SOS: begin
          if (resync) begin
            sos_step_next     = '0;
            sos_deadline_next = item.count + CNT_W'(1);
          end else if (due) begin
            led_level_next    = (sos_step == '0) ? 1'b0 : !led_level;
            sos_deadline_next = item.count + gap;
            sos_step_next     = (sos_step >= STEP_LAST) ? STEP_W'(1)
                                                        : sos_step + STEP_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      light_mode   <= MODE_OFF;
      led_level    <= 1'b0;
      sos_step     <= '0;
      sos_deadline <= '0;
    end else if (item_take) begin
      light_mode   <= light_mode_next;
      led_level    <= led_level_next;
      sos_step     <= sos_step_next;
      sos_deadline <= sos_deadline_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (item_take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      res_led  <= led_level_next;
      res_mode <= light_mode_next;
    end
  end

  assign m_axis_tdata = {{(OUT_DW-3){1'b0}}, res_mode, res_led};

endmodule

`default_nettype wire
